// ===== hw/rtl/gfa_pkg.sv =====
// Shared types, constants and table builders for the GF(2^8) arithmetic unit.
// The log and antilog tables are computed at elaboration from the field polynomial.
// No dependencies.
package gfa_pkg;

  localparam logic [8:0] GfPoly  = 9'h11D;
  localparam logic [7:0] GfOrder = 8'd255;
  localparam int unsigned TblDepth = 256;

  typedef enum logic [1:0] {
    MODE_MUL = 2'd0,
    MODE_INV = 2'd1,
    MODE_POW = 2'd2,
    MODE_MAC = 2'd3
  } mode_e;

  typedef logic [7:0] byte_tbl_t [TblDepth];

  // Antilog table: entry i holds alpha^i with alpha = x. Entry 255 wraps to 1.
  function automatic byte_tbl_t build_exp_tbl();
    byte_tbl_t  tbl;
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < TblDepth; i++) begin
      tbl[i] = x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GfPoly;
      end
    end
    return tbl;
  endfunction

  // Log table: entry for zero is never used and reads as zero.
  function automatic byte_tbl_t build_log_tbl();
    byte_tbl_t exp_tbl;
    byte_tbl_t tbl;
    exp_tbl = build_exp_tbl();
    tbl = '{default: 8'd0};
    for (int i = 0; i < int'(GfOrder); i++) begin
      tbl[exp_tbl[i]] = 8'(i);
    end
    return tbl;
  endfunction

endpackage

// ===== hw/rtl/gfa_log_rom.sv =====
// Log table memory with two synchronous read ports; read data is registered.
// Depends on gfa_pkg for the table contents.
module gfa_log_rom (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] addr_a_i,
  input  logic [7:0] addr_b_i,
  output logic [7:0] data_a_o,
  output logic [7:0] data_b_o
);
  import gfa_pkg::*;

  localparam byte_tbl_t LogMem = build_log_tbl();

  logic [7:0] data_a_q;
  logic [7:0] data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= LogMem[addr_a_i];
      data_b_q <= LogMem[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

// ===== hw/rtl/gfa_exp_rom.sv =====
// Antilog table memory with one synchronous read port; read data is registered.
// Depends on gfa_pkg for the table contents.
module gfa_exp_rom (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] addr_i,
  output logic [7:0] data_o
);
  import gfa_pkg::*;

  localparam byte_tbl_t ExpMem = build_exp_tbl();

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ExpMem[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/gf256_arith_unit.sv =====
// GF(2^8) arithmetic unit (polynomial 0x11D): multiply, inverse, power, multiply-accumulate.
// Throughput one word per cycle while m_axis_tready does not stall the output.
// The path is log memory read, log-domain add, subtract or multiply, mod-255 fold, antilog memory read.
// Each stage stalls only when the stage after it is full and not moving.
// Reset (rst_ni low, asynchronous) empties every stage; the tables need no initialization.
// Depends on gfa_pkg, gfa_log_rom and gfa_exp_rom.
module gf256_arith_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // operand_a[7:0], operand_b[15:8], exponent[31:16],
                                      // accum_in[39:32]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // result[7:0]
  output logic        m_axis_tlast    // last_out
);
  import gfa_pkg::*;

  // Input field views.
  logic [7:0]  in_a;
  logic [7:0]  in_b;
  logic [15:0] in_exp;
  logic [7:0]  in_acc;
  mode_e       in_mode;

  assign in_a    = s_axis_tdata[7:0];
  assign in_b    = s_axis_tdata[15:8];
  assign in_exp  = s_axis_tdata[31:16];
  assign in_acc  = s_axis_tdata[39:32];
  assign in_mode = mode_e'(s_axis_tuser);

  // Stage enables: a stage may load when it is empty or its content moves on.
  logic en1, en2, en3, en_out;
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;

  assign en_out = !out_vld_q || m_axis_tready;
  assign en3    = !s3_vld_q || en_out;
  assign en2    = !s2_vld_q || en3;
  assign en1    = !s1_vld_q || en2;

  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1)    s1_vld_q  <= s_axis_tvalid;
      if (en2)    s2_vld_q  <= s1_vld_q;
      if (en3)    s3_vld_q  <= s2_vld_q;
      if (en_out) out_vld_q <= s3_vld_q;
    end
  end

  // Stage 1: log lookups of both operands, side fields registered alongside.
  logic [7:0]  s1_log_a, s1_log_b;
  mode_e       s1_mode_q;
  logic [15:0] s1_exp_q;
  logic [7:0]  s1_acc_q;
  logic        s1_last_q;
  logic        s1_a_zero_q;
  logic        s1_b_zero_q;

  gfa_log_rom u_log_rom (
    .clk_i    (clk_i),
    .en_i     (en1),
    .addr_a_i (in_a),
    .addr_b_i (in_b),
    .data_a_o (s1_log_a),
    .data_b_o (s1_log_b)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mode_q   <= in_mode;
      s1_exp_q    <= in_exp;
      s1_acc_q    <= in_acc;
      s1_last_q   <= s_axis_tlast;
      s1_a_zero_q <= (in_a == 8'd0);
      s1_b_zero_q <= (in_b == 8'd0);
    end
  end

  // Stage 2: exponent of the result in the log domain, not yet reduced mod 255.
  logic [23:0] s2_log_d;
  logic        s2_zero_d, s2_one_d;
  logic [23:0] s2_log_q;
  logic        s2_zero_q, s2_one_q, s2_mac_q, s2_last_q;
  logic [7:0]  s2_acc_q;

  always_comb begin
    s2_log_d  = 24'd0;
    s2_zero_d = 1'b0;
    s2_one_d  = 1'b0;
    case (s1_mode_q)
      MODE_MUL, MODE_MAC: begin
        s2_log_d  = 24'(s1_log_a) + 24'(s1_log_b);
        s2_zero_d = s1_a_zero_q || s1_b_zero_q;
      end
      MODE_INV: begin
        s2_log_d  = 24'(GfOrder) - 24'(s1_log_a);
        s2_zero_d = s1_a_zero_q;
      end
      MODE_POW: begin
        s2_log_d  = {16'd0, s1_log_a} * {8'd0, s1_exp_q};
        // A zero exponent gives one, even for a zero base.
        s2_one_d  = (s1_exp_q == 16'd0);
        s2_zero_d = s1_a_zero_q && (s1_exp_q != 16'd0);
      end
      default: begin
        s2_log_d = 24'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_log_q  <= s2_log_d;
      s2_zero_q <= s2_zero_d;
      s2_one_q  <= s2_one_d;
      s2_mac_q  <= (s1_mode_q == MODE_MAC);
      s2_acc_q  <= s1_acc_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: fold the log value mod 255 (2^8 = 1 mod 255) and read the antilog.
  logic [9:0] fold1;
  logic [8:0] fold2;
  logic [7:0] exp_idx;

  assign fold1   = 10'(s2_log_q[7:0]) + 10'(s2_log_q[15:8]) + 10'(s2_log_q[23:16]);
  assign fold2   = 9'(fold1[7:0]) + 9'(fold1[9:8]);
  assign exp_idx = (fold2 >= 9'(GfOrder)) ? 8'(fold2 - 9'(GfOrder)) : fold2[7:0];

  logic [7:0] s3_alog;
  logic       s3_zero_q, s3_one_q, s3_mac_q, s3_last_q;
  logic [7:0] s3_acc_q;

  gfa_exp_rom u_exp_rom (
    .clk_i  (clk_i),
    .en_i   (en3),
    .addr_i (exp_idx),
    .data_o (s3_alog)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_zero_q <= s2_zero_q;
      s3_one_q  <= s2_one_q;
      s3_mac_q  <= s2_mac_q;
      s3_acc_q  <= s2_acc_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Output register.
  logic [7:0] field_val;
  logic [7:0] res_d;
  logic [7:0] res_q;
  logic       last_q;

  always_comb begin
    if (s3_one_q) begin
      field_val = 8'd1;
    end else if (s3_zero_q) begin
      field_val = 8'd0;
    end else begin
      field_val = s3_alog;
    end
    res_d = s3_mac_q ? (s3_acc_q ^ field_val) : field_val;
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      res_q  <= res_d;
      last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = last_q;

  // The pipeline never drops a word from stage 1 into stage 2 or from stage 3 into the output.
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && en2) |=> s2_vld_q)
    else $error("stage 1 word lost");

  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_vld_q && en_out) |=> out_vld_q)
    else $error("stage 3 word lost");

  // A new output word can only come from a filled stage 3.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s3_vld_q))
    else $error("output valid without a source word");

  // A word waiting at the output blocks stage 3 from being overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready && s3_vld_q) |-> !en3)
    else $error("stage 3 advanced into a stalled output");

endmodule
